### hdl/hmt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the modulo hash table.
package hmt_pkg;

	localparam int KIND_W   = 2;
	localparam int KEY_W    = 31;
	localparam int PAY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int BKT_W    = 4;
	localparam int CFG_W    = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_DIV,
		S_FRD,
		S_FCHK,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SH_RD,
		S_SH_WR
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

endpackage

### hdl/hmt_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring modulo unit: key modulo a 5-bit divisor, one bit a cycle.
module hmt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hmt_pkg::KEY_W-1:0]   dividend,
	input  logic [hmt_pkg::CFG_W-1:0]   divisor,
	output logic                        done,
	output logic [hmt_pkg::CFG_W-1:0]   remainder
);
	import hmt_pkg::*;

	localparam int CNT_W = $clog2(KEY_W);

	logic [KEY_W-1:0] dvd_q;
	logic [CFG_W-1:0] d_q;
	logic [CFG_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [CFG_W:0]   trial;
	logic [CFG_W-1:0] rem_nxt;

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[KEY_W-1]};
		if (trial >= {1'b0, d_q}) begin
			rem_nxt = CFG_W'(trial - {1'b0, d_q});
		end else begin
			rem_nxt = CFG_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(KEY_W - 1);
			rem_q  <= '0;
		end else if (run_q) begin
			rem_q <= rem_nxt;
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			d_q   <= divisor;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

### hdl/modulo_hash_table_top.sv
`timescale 1ns / 1ps
// Top level of the modulo hash table: sequencer, entry store and fill counts.
//
// Keyed table of fixed-size buckets. A transaction is taken on a rising edge
// with start high and busy low; kind selects insert, lookup or remove, key is
// hashed to bucket = key mod bucket_count, payload is stored by insert.
// Each bucket holds WAYS entries in insertion order; remove closes the gap.
// Exactly one result per transaction: done is high for one cycle while
// status, found_payload and bucket hold the answer. The receiver cannot
// stall, so the result must be captured in that cycle.
// The user must write bucket_count through cfg_we/cfg_wdata while the block
// is idle, unchecked here; 0 acts as 1 and values above MAX_BUCKETS saturate.
// Sequence: the bit-serial modulo unit takes 31 steps and then its done strobe;
// the bucket fill is read and checked, then for lookup and remove the ways are
// read and compared in turn, and on remove each later way is read and shifted
// down; the result register then raises done. One transaction at a time: busy
// drops in the cycle done rises, so the next one can be taken then.
// The modulo unit and the entry store, with its one read port, set the pace.
// After reset the fill counts are cleared by a sweep over all MAX_BUCKETS
// buckets, during which busy is high; the entry store itself is not cleared.
module modulo_hash_table_top #(
	parameter int MAX_BUCKETS = 16,
	parameter int WAYS        = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [hmt_pkg::KIND_W-1:0]    kind,
	input  logic [hmt_pkg::KEY_W-1:0]     key,
	input  logic [hmt_pkg::PAY_W-1:0]     payload,
	output logic                          done,
	output logic [hmt_pkg::STATUS_W-1:0]  status,
	output logic [hmt_pkg::PAY_W-1:0]     found_payload,
	output logic [hmt_pkg::BKT_W-1:0]     bucket,
	input  logic                          cfg_we,
	input  logic [hmt_pkg::CFG_W-1:0]     cfg_wdata
);
	import hmt_pkg::*;

	localparam int DEPTH = MAX_BUCKETS * WAYS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int FW    = $clog2(WAYS + 1);

	// configuration
	logic [CFG_W-1:0] bucket_count_q;
	logic [CFG_W-1:0] divisor;

	// transaction registers
	state_t           state_q, state_nxt;
	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [CFG_W-1:0] rem_q;
	logic [FW-1:0]    way_q, way_nxt;
	logic [BW-1:0]    clr_cnt_q;
	logic [BW-1:0]    bkt;

	// modulo unit
	logic             div_start;
	logic             div_done;
	logic [CFG_W-1:0] div_rem;

	// memories
	entry_t           ent_mem [DEPTH];
	entry_t           ent_rd_q;
	logic             ent_we;
	logic [AW-1:0]    ent_waddr, ent_raddr;
	entry_t           ent_wdata;

	logic [FW-1:0]    fill_mem [MAX_BUCKETS];
	logic [FW-1:0]    fill_rd_q;
	logic             fill_re;
	logic             fill_we;
	logic [BW-1:0]    fill_waddr;
	logic [FW-1:0]    fill_wdata;

	// result
	logic             resp_en;
	status_t          resp_status;
	logic [PAY_W-1:0] resp_found;
	logic             done_q;
	logic [STATUS_W-1:0] status_q;
	logic [PAY_W-1:0] found_q;
	logic [BKT_W-1:0] bucket_q;

	function automatic logic [AW-1:0] ent_addr(input logic [BW-1:0] b, input logic [FW-1:0] w);
		ent_addr = AW'(b) * AW'(WAYS) + AW'(w);
	endfunction

	// 0 acts as 1, saturate at MAX_BUCKETS
	always_comb begin
		if (bucket_count_q == '0) begin
			divisor = CFG_W'(1);
		end else if (int'(bucket_count_q) > MAX_BUCKETS) begin
			divisor = CFG_W'(MAX_BUCKETS);
		end else begin
			divisor = bucket_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CFG_W'(16);
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	assign div_start = start && (state_q == S_IDLE);

	hmt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (key),
		.divisor   (divisor),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign bkt = BW'(rem_q);

	// sequencer
	always_comb begin
		state_nxt   = state_q;
		way_nxt     = way_q;
		ent_we      = 1'b0;
		ent_waddr   = ent_addr(bkt, way_q);
		ent_wdata   = ent_rd_q;
		ent_raddr   = ent_addr(bkt, way_q);
		fill_re     = 1'b0;
		fill_we     = 1'b0;
		fill_waddr  = bkt;
		fill_wdata  = fill_rd_q;
		resp_en     = 1'b0;
		resp_status = ST_MISS;
		resp_found  = '0;
		unique case (state_q)
			S_CLR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_cnt_q;
				fill_wdata = '0;
				if (clr_cnt_q == BW'(MAX_BUCKETS - 1)) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_nxt = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_nxt = S_FRD;
				end
			end
			S_FRD: begin
				fill_re   = 1'b1;
				state_nxt = S_FCHK;
			end
			S_FCHK: begin
				way_nxt = '0;
				unique case (kind_q)
					KIND_INSERT: begin
						state_nxt = S_IDLE;
						resp_en   = 1'b1;
						if (fill_rd_q >= FW'(WAYS)) begin
							resp_status = ST_FULL;
						end else begin
							ent_we      = 1'b1;
							ent_waddr   = ent_addr(bkt, fill_rd_q);
							ent_wdata   = '{key: key_q, payload: pay_q};
							fill_we     = 1'b1;
							fill_wdata  = fill_rd_q + FW'(1);
							resp_status = ST_OK;
						end
					end
					KIND_LOOKUP, KIND_REMOVE: begin
						if (fill_rd_q == '0) begin
							state_nxt = S_IDLE;
							resp_en   = 1'b1;
						end else begin
							state_nxt = S_SCAN_RD;
						end
					end
					default: begin
						// no-op request
						state_nxt = S_IDLE;
						resp_en   = 1'b1;
					end
				endcase
			end
			S_SCAN_RD: begin
				state_nxt = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (ent_rd_q.key == key_q) begin
					if (kind_q == KIND_LOOKUP) begin
						state_nxt   = S_IDLE;
						resp_en     = 1'b1;
						resp_status = ST_OK;
						resp_found  = ent_rd_q.payload;
					end else begin
						fill_we    = 1'b1;
						fill_wdata = fill_rd_q - FW'(1);
						if ({1'b0, way_q} + (FW+1)'(1) < {1'b0, fill_rd_q}) begin
							state_nxt = S_SH_RD;
						end else begin
							state_nxt   = S_IDLE;
							resp_en     = 1'b1;
							resp_status = ST_OK;
						end
					end
				end else if ({1'b0, way_q} + (FW+1)'(1) == {1'b0, fill_rd_q}) begin
					state_nxt = S_IDLE;
					resp_en   = 1'b1;
				end else begin
					way_nxt   = way_q + FW'(1);
					state_nxt = S_SCAN_RD;
				end
			end
			S_SH_RD: begin
				ent_raddr = ent_addr(bkt, FW'(way_q + FW'(1)));
				state_nxt = S_SH_WR;
			end
			S_SH_WR: begin
				ent_we  = 1'b1;
				way_nxt = way_q + FW'(1);
				if ({1'b0, way_q} + (FW+1)'(2) < {1'b0, fill_rd_q}) begin
					state_nxt = S_SH_RD;
				end else begin
					state_nxt   = S_IDLE;
					resp_en     = 1'b1;
					resp_status = ST_OK;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_cnt_q <= '0;
			way_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			way_q   <= way_nxt;
			done_q  <= resp_en;
			if (state_q == S_CLR) begin
				clr_cnt_q <= clr_cnt_q + BW'(1);
			end
		end
	end

	// transaction payload, no reset needed
	always_ff @(posedge clk) begin
		if (div_start) begin
			kind_q <= kind;
			key_q  <= key;
			pay_q  <= payload;
		end
		if (div_done) begin
			rem_q <= div_rem;
		end
		if (resp_en) begin
			status_q <= resp_status;
			found_q  <= resp_found;
			bucket_q <= rem_q[BKT_W-1:0];
		end
	end

	// entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		ent_rd_q <= ent_mem[ent_raddr];
	end

	// fill counts, cleared by the sweep after reset
	always_ff @(posedge clk) begin
		if (fill_we) begin
			fill_mem[fill_waddr] <= fill_wdata;
		end
		if (fill_re) begin
			fill_rd_q <= fill_mem[bkt];
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign found_payload = found_q;
	assign bucket        = bucket_q;

	// a result is only given once the sequencer is back at rest
	a_done_idle : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted transaction keeps the block busy
	a_start_busy : assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not raise busy");

	// a payload is only returned with a found status
	a_found_ok : assert property (@(posedge clk) disable iff (!arst_n)
		done && (found_payload != '0) |-> status == ST_OK)
		else $error("payload returned without a hit");

	// the modulo result never reaches the divisor
	a_rem_range : assert property (@(posedge clk) disable iff (!arst_n)
		$past(div_done) |-> rem_q < divisor)
		else $error("bucket index out of range");

endmodule
